FILE: src/differential_drive_odometry_assert.svh
// ----------------------------------------------------------------------------
// Odometry assertion macros
// Concurrent checks shared by the odometry RTL, clocked on the rising edge
// and held off while the synchronous reset is asserted.
// ----------------------------------------------------------------------------
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH

// same-cycle implication
`define DDO_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("odometry assertion failed");

// next-cycle implication
`define DDO_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("odometry assertion failed");

`endif

FILE: src/ddo_pkg.sv
// ----------------------------------------------------------------------------
// Odometry package
// Shared widths, fixed-point constants, codes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package ddo_pkg;

    localparam int WORD_W     = 32;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_DATA_W  = 160;
    localparam int OUT_DATA_W = 96;

    // bit-serial multiplier: 65-bit multiplicand, 32-bit multiplier
    localparam int MUL_A_W   = 65;
    localparam int MUL_B_W   = 32;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = 6;

    localparam int ITER_W     = 6;
    localparam int ATAN_IDX_W = 5;

    localparam logic [WORD_W-1:0] TWO_PI_Q29        = 32'd3373259426;
    localparam logic [WORD_W-1:0] PI_Q29            = 32'd1686629713;
    localparam logic [WORD_W-1:0] HALF_PI_Q29       = 32'd843314857;
    localparam logic [WORD_W-1:0] THREE_HALF_PI_Q29 = 32'd2529944570;
    localparam logic [WORD_W-1:0] CORDIC_GAIN_Q30   = 32'd652032874;
    localparam logic [WORD_W-1:0] INV_TRACK_RESET   = 32'd1864135;
    localparam logic [WORD_W-1:0] POS_MAX           = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] POS_MIN           = 32'h8000_0000;

    typedef enum logic [OP_W-1:0] {
        OP_UPDATE    = 2'd0,
        OP_SET_POSE  = 2'd1,
        OP_SET_LATCH = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIST_PER_COUNT = 2'd0,
        REG_INV_TRACK      = 2'd1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DELTA,
        ST_DIFF_MUL,
        ST_TURN_MUL,
        ST_TURN,
        ST_WRAP,
        ST_LAUNCH,
        ST_ROTATE,
        ST_X_MUL,
        ST_Y_MUL,
        ST_EMIT
    } state_t;

    // CORDIC result as sign and magnitude, ready for the unsigned multiplier
    typedef struct packed {
        logic              cos_neg;
        logic [WORD_W-1:0] cos_mag;
        logic              sin_neg;
        logic [WORD_W-1:0] sin_mag;
    } trig_t;

    function automatic logic [WORD_W-1:0] atan_q29(input logic [ATAN_IDX_W-1:0] idx);
        logic [WORD_W-1:0] val;
        case (idx)
            5'd0:    val = 32'd421657428;
            5'd1:    val = 32'd248918915;
            5'd2:    val = 32'd131521918;
            5'd3:    val = 32'd66762579;
            5'd4:    val = 32'd33510843;
            5'd5:    val = 32'd16771758;
            5'd6:    val = 32'd8387925;
            5'd7:    val = 32'd4194219;
            5'd8:    val = 32'd2097141;
            5'd9:    val = 32'd1048575;
            5'd10:   val = 32'd524288;
            5'd11:   val = 32'd262144;
            5'd12:   val = 32'd131072;
            5'd13:   val = 32'd65536;
            5'd14:   val = 32'd32768;
            5'd15:   val = 32'd16384;
            5'd16:   val = 32'd8192;
            5'd17:   val = 32'd4096;
            5'd18:   val = 32'd2048;
            5'd19:   val = 32'd1024;
            5'd20:   val = 32'd512;
            5'd21:   val = 32'd256;
            5'd22:   val = 32'd128;
            5'd23:   val = 32'd64;
            5'd24:   val = 32'd32;
            5'd25:   val = 32'd16;
            5'd26:   val = 32'd8;
            5'd27:   val = 32'd4;
            5'd28:   val = 32'd2;
            5'd29:   val = 32'd1;
            default: val = 32'd0;
        endcase
        return val;
    endfunction

endpackage

FILE: src/differential_drive_odometry.sv
// Flow: one item at a time; a count update runs the states from ST_DELTA to ST_EMIT,
// while a pose load or an unused op goes straight from ST_IDLE to ST_EMIT.
// A count update makes five passes of the shared bit-serial multiplier (the
// distance-sum pass runs under the CORDIC). No new item is taken until the result
// is loaded into the output register in ST_EMIT, which waits on m_tready.
// Reset: synchronous, active low; pose, heading and reference counts clear to 0.
// ----------------------------------------------------------------------------
// Differential-drive odometry
// Dead reckoning from wheel encoder counts: heading from the wheel difference,
// x and y from the mean travel times cos and sin of the new heading.
// ----------------------------------------------------------------------------
`include "differential_drive_odometry_assert.svh"

module differential_drive_odometry #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // count_right, count_left, pose_x, pose_y, pose_heading
    input  logic [ddo_pkg::IN_DATA_W-1:0]  s_tdata,
    // op
    input  logic [ddo_pkg::OP_W-1:0]       s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // out_x, out_y, out_heading
    output logic [ddo_pkg::OUT_DATA_W-1:0] m_tdata,
    // saturated
    output logic                           m_tuser,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ddo_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ddo_pkg::WORD_W-1:0]     cfg_data
);
    import ddo_pkg::*;

    localparam int AXIS_W = 59;
    localparam int HEAD_W = WORD_W + 2;

    state_t state_reg;
    state_t state_next;

    logic [WORD_W-1:0]        dpc_reg;
    logic [WORD_W-1:0]        inv_track_reg;
    logic [WORD_W-1:0]        pos_x_reg;
    logic [WORD_W-1:0]        pos_y_reg;
    logic [WORD_W-1:0]        heading_reg;
    logic [WORD_W-1:0]        ref_right_reg;
    logic [WORD_W-1:0]        ref_left_reg;

    logic [WORD_W-1:0]        dr_reg;
    logic [WORD_W-1:0]        dl_reg;
    logic                     diff_neg_reg;
    logic                     sum_neg_reg;
    logic [WORD_W:0]          sum_mag_reg;
    logic [WORD_W-1:0]        tm_reg;
    logic signed [HEAD_W-1:0] h_reg;
    logic [MUL_A_W-1:0]       sm_reg;
    logic                     sat_reg;

    logic                     m_tvalid_reg;
    logic [OUT_DATA_W-1:0]    m_tdata_reg;
    logic                     m_tuser_reg;

    logic                     mul_start;
    logic [MUL_A_W-1:0]       mul_a;
    logic [MUL_B_W-1:0]       mul_b;
    logic                     mul_busy;
    logic [MUL_P_W-1:0]       mul_product;
    logic                     cor_start;
    logic                     cor_busy;
    trig_t                    trig;

    logic                     accept;
    logic [WORD_W:0]          diff_w;
    logic [WORD_W:0]          sum_w;
    logic [WORD_W:0]          diff_mag;
    logic [WORD_W:0]          sum_mag;
    logic [WORD_W-1:0]        tm_next;
    logic signed [HEAD_W-1:0] h_next;
    logic [WORD_W-1:0]        wrap_next;
    logic [WORD_W-1:0]        pose_heading_clip;
    logic [WORD_W-1:0]        axis_p;
    logic                     axis_neg;
    logic [AXIS_W-1:0]        axis_r;
    logic                     axis_sat;
    logic [WORD_W-1:0]        axis_next;

    ddo_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .busy    (mul_busy),
        .product (mul_product)
    );

    ddo_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cor_start),
        .angle   (heading_reg),
        .busy    (cor_busy),
        .trig    (trig)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    // wheel sum and difference, sign and magnitude
    assign diff_w   = {dr_reg[WORD_W-1], dr_reg} - {dl_reg[WORD_W-1], dl_reg};
    assign sum_w    = {dr_reg[WORD_W-1], dr_reg} + {dl_reg[WORD_W-1], dl_reg};
    assign diff_mag = diff_w[WORD_W] ? (WORD_W+1)'(-diff_w) : diff_w;
    assign sum_mag  = sum_w[WORD_W] ? (WORD_W+1)'(-sum_w) : sum_w;

    // heading change in Q3.29: product shifted down by 19, clipped at 2pi
    assign tm_next = ((|mul_product[MUL_P_W-1:51]) || (mul_product[50:19] > TWO_PI_Q29))
                   ? TWO_PI_Q29 : mul_product[50:19];

    assign h_next = diff_neg_reg
                  ? $signed({2'b00, heading_reg} - {2'b00, tm_reg})
                  : $signed({2'b00, heading_reg} + {2'b00, tm_reg});

    always_comb begin
        if (h_reg > $signed({2'b00, TWO_PI_Q29})) begin
            wrap_next = WORD_W'(h_reg - $signed({2'b00, TWO_PI_Q29}));
        end else if (h_reg < 0) begin
            wrap_next = WORD_W'(h_reg + $signed({2'b00, TWO_PI_Q29}));
        end else begin
            wrap_next = h_reg[WORD_W-1:0];
        end
    end

    assign pose_heading_clip = (s_tdata[159:128] > TWO_PI_Q29) ? TWO_PI_Q29 : s_tdata[159:128];

    // one saturating adder serves both axes
    always_comb begin
        if (state_reg == ST_X_MUL) begin
            axis_p   = pos_x_reg;
            axis_neg = sum_neg_reg ^ trig.cos_neg;
        end else begin
            axis_p   = pos_y_reg;
            axis_neg = sum_neg_reg ^ trig.sin_neg;
        end
        if (axis_neg) begin
            axis_r = {{(AXIS_W-WORD_W){axis_p[WORD_W-1]}}, axis_p}
                   - {2'b00, mul_product[95:39]};
        end else begin
            axis_r = {{(AXIS_W-WORD_W){axis_p[WORD_W-1]}}, axis_p}
                   + {2'b00, mul_product[95:39]};
        end
        axis_sat = !((&axis_r[AXIS_W-1:WORD_W-1]) || !(|axis_r[AXIS_W-1:WORD_W-1]));
        if (axis_sat) begin
            axis_next = axis_r[AXIS_W-1] ? POS_MIN : POS_MAX;
        end else begin
            axis_next = axis_r[WORD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        mul_start  = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        cor_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = (s_tuser == OP_UPDATE) ? ST_DELTA : ST_EMIT;
                end
            end
            ST_DELTA: begin
                mul_start  = 1'b1;
                mul_a      = MUL_A_W'(diff_mag);
                mul_b      = dpc_reg;
                state_next = ST_DIFF_MUL;
            end
            ST_DIFF_MUL: begin
                if (!mul_busy) begin
                    mul_start  = 1'b1;
                    mul_a      = mul_product[MUL_A_W-1:0];
                    mul_b      = inv_track_reg;
                    state_next = ST_TURN_MUL;
                end
            end
            ST_TURN_MUL: begin
                if (!mul_busy) begin
                    state_next = ST_TURN;
                end
            end
            ST_TURN: begin
                state_next = ST_WRAP;
            end
            ST_WRAP: begin
                state_next = ST_LAUNCH;
            end
            ST_LAUNCH: begin
                cor_start  = 1'b1;
                mul_start  = 1'b1;
                mul_a      = MUL_A_W'(sum_mag_reg);
                mul_b      = dpc_reg;
                state_next = ST_ROTATE;
            end
            ST_ROTATE: begin
                if (!mul_busy && !cor_busy) begin
                    mul_start  = 1'b1;
                    mul_a      = mul_product[MUL_A_W-1:0];
                    mul_b      = trig.cos_mag;
                    state_next = ST_X_MUL;
                end
            end
            ST_X_MUL: begin
                if (!mul_busy) begin
                    mul_start  = 1'b1;
                    mul_a      = sm_reg;
                    mul_b      = trig.sin_mag;
                    state_next = ST_Y_MUL;
                end
            end
            ST_Y_MUL: begin
                if (!mul_busy) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dpc_reg       <= '0;
            inv_track_reg <= INV_TRACK_RESET;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            heading_reg   <= '0;
            ref_right_reg <= '0;
            ref_left_reg  <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_DIST_PER_COUNT: dpc_reg       <= cfg_data;
                    REG_INV_TRACK:      inv_track_reg <= cfg_data;
                    default: ;
                endcase
            end
            // load a new item or drop the one just taken
            if (state_reg == ST_EMIT && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        sat_reg <= 1'b0;
                        case (s_tuser)
                            OP_UPDATE: begin
                                dr_reg        <= s_tdata[31:0] - ref_right_reg;
                                dl_reg        <= s_tdata[63:32] - ref_left_reg;
                                ref_right_reg <= s_tdata[31:0];
                                ref_left_reg  <= s_tdata[63:32];
                            end
                            OP_SET_POSE: begin
                                pos_x_reg   <= s_tdata[95:64];
                                pos_y_reg   <= s_tdata[127:96];
                                heading_reg <= pose_heading_clip;
                            end
                            OP_SET_LATCH: begin
                                pos_x_reg     <= s_tdata[95:64];
                                pos_y_reg     <= s_tdata[127:96];
                                heading_reg   <= pose_heading_clip;
                                ref_right_reg <= s_tdata[31:0];
                                ref_left_reg  <= s_tdata[63:32];
                            end
                            default: ;
                        endcase
                    end
                end
                ST_DELTA: begin
                    diff_neg_reg <= diff_w[WORD_W];
                    sum_neg_reg  <= sum_w[WORD_W];
                    sum_mag_reg  <= sum_mag;
                end
                ST_TURN_MUL: begin
                    if (!mul_busy) begin
                        tm_reg <= tm_next;
                    end
                end
                ST_TURN: begin
                    h_reg <= h_next;
                end
                ST_WRAP: begin
                    heading_reg <= wrap_next;
                end
                ST_ROTATE: begin
                    // keep the scaled travel for the y pass
                    if (!mul_busy && !cor_busy) begin
                        sm_reg <= mul_product[MUL_A_W-1:0];
                    end
                end
                ST_X_MUL: begin
                    if (!mul_busy) begin
                        pos_x_reg <= axis_next;
                        sat_reg   <= sat_reg | axis_sat;
                    end
                end
                ST_Y_MUL: begin
                    if (!mul_busy) begin
                        pos_y_reg <= axis_next;
                        sat_reg   <= sat_reg | axis_sat;
                    end
                end
                ST_EMIT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= {heading_reg, pos_y_reg, pos_x_reg};
                        m_tuser_reg  <= sat_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    `DDO_ASSERT_IMPLY(a_heading_range, aclk, aresetn, 1'b1, heading_reg <= TWO_PI_Q29)
    `DDO_ASSERT_IMPLY(a_mul_free, aclk, aresetn, mul_start, !mul_busy)
    `DDO_ASSERT_IMPLY(a_cordic_free, aclk, aresetn, cor_start, !cor_busy)
    `DDO_ASSERT_NEXT(a_one_item, aclk, aresetn, accept, !s_tready)

endmodule

FILE: src/ddo_mul.sv
// ----------------------------------------------------------------------------
// Bit-serial multiplier
// Unsigned 65 x 32 multiply, one multiplier bit per cycle through a
// right-shifting product register; the product holds until the next start.
// ----------------------------------------------------------------------------
module ddo_mul (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [ddo_pkg::MUL_A_W-1:0]  a,
    input  logic [ddo_pkg::MUL_B_W-1:0]  b,
    output logic                         busy,
    output logic [ddo_pkg::MUL_P_W-1:0]  product
);
    import ddo_pkg::*;

    logic                 busy_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic [MUL_A_W-1:0]   a_reg;
    logic [MUL_P_W-1:0]   prod_reg;
    logic [MUL_P_W-1:0]   prod_next;
    logic [MUL_A_W:0]     part_sum;

    // add the multiplicand into the upper half when the low bit is set, then shift
    assign part_sum  = {1'b0, prod_reg[MUL_P_W-1:MUL_B_W]}
                     + (prod_reg[0] ? {1'b0, a_reg} : {(MUL_A_W+1){1'b0}});
    assign prod_next = {part_sum, prod_reg[MUL_B_W-1:1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == MUL_CNT_W'(MUL_B_W - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg    <= a;
            prod_reg <= {{MUL_A_W{1'b0}}, b};
        end else if (busy_reg) begin
            prod_reg <= prod_next;
        end
    end

    assign busy    = busy_reg;
    assign product = prod_reg;

endmodule

FILE: src/ddo_cordic.sv
// ----------------------------------------------------------------------------
// Iterative CORDIC
// Cos and sin of a Q3.29 heading in [0, 2pi], Q2.30 results, one rotation
// per cycle after a quadrant fold in the start cycle.
// ----------------------------------------------------------------------------
module ddo_cordic #(
    parameter int STEPS = 24
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [ddo_pkg::WORD_W-1:0]  angle,
    output logic                        busy,
    output ddo_pkg::trig_t              trig
);
    import ddo_pkg::*;

    logic                     busy_reg;
    logic [ITER_W-1:0]        iter_reg;
    logic signed [WORD_W-1:0] x_reg;
    logic signed [WORD_W-1:0] y_reg;
    logic signed [WORD_W-1:0] z_reg;
    logic                     neg_reg;

    logic [ATAN_IDX_W-1:0]    sh;
    logic signed [WORD_W-1:0] x_sh;
    logic signed [WORD_W-1:0] y_sh;
    logic signed [WORD_W-1:0] at;
    logic [WORD_W-1:0]        z_fold;
    logic                     neg_fold;

    assign sh   = iter_reg[ATAN_IDX_W-1:0];
    assign x_sh = x_reg >>> sh;
    assign y_sh = y_reg >>> sh;
    assign at   = $signed(atan_q29(sh));

    // fold into [-pi/2, pi/2]; the middle half-turn flips both results
    always_comb begin
        if (angle > THREE_HALF_PI_Q29) begin
            z_fold   = angle - TWO_PI_Q29;
            neg_fold = 1'b0;
        end else if (angle > HALF_PI_Q29) begin
            z_fold   = angle - PI_Q29;
            neg_fold = 1'b1;
        end else begin
            z_fold   = angle;
            neg_fold = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            iter_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            iter_reg <= '0;
        end else if (busy_reg) begin
            iter_reg <= iter_reg + 1'b1;
            if (iter_reg == ITER_W'(STEPS - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg   <= $signed(CORDIC_GAIN_Q30);
            y_reg   <= '0;
            z_reg   <= $signed(z_fold);
            neg_reg <= neg_fold;
        end else if (busy_reg) begin
            if (z_reg >= 0) begin
                x_reg <= x_reg - y_sh;
                y_reg <= y_reg + x_sh;
                z_reg <= z_reg - at;
            end else begin
                x_reg <= x_reg + y_sh;
                y_reg <= y_reg - x_sh;
                z_reg <= z_reg + at;
            end
        end
    end

    assign busy         = busy_reg;
    assign trig.cos_neg = neg_reg ^ x_reg[WORD_W-1];
    assign trig.cos_mag = x_reg[WORD_W-1] ? WORD_W'(-x_reg) : WORD_W'(x_reg);
    assign trig.sin_neg = neg_reg ^ y_reg[WORD_W-1];
    assign trig.sin_mag = y_reg[WORD_W-1] ? WORD_W'(-y_reg) : WORD_W'(y_reg);

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Odometry testbench
// Sends count updates, pose loads and unused ops through the stream ports
// with bursty input and a stalling result side. A fixed-point pose predictor
// checks every result field, and the registers are rewritten between phases
// so that the run sees zero, full-scale and typical scale factors.
// ----------------------------------------------------------------------------
module tb;
    import ddo_pkg::*;

    localparam int CORDIC_STEPS    = 24;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 288;
    localparam int STALL_LIMIT     = 2000;
    localparam int SETTLE_CYCLES   = 200;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam longint TWO_PI        = longint'(TWO_PI_Q29);
    localparam longint HALF_TURN     = longint'(PI_Q29);
    localparam longint QUARTER_TURN  = longint'(HALF_PI_Q29);
    localparam longint THREE_QUARTER = longint'(THREE_HALF_PI_Q29);
    localparam longint POS_HI        = longint'($signed(POS_MAX));
    localparam longint POS_LO        = longint'($signed(POS_MIN));

    localparam longint ATAN_STEP [32] = '{
        421657428, 248918915, 131521918, 66762579, 33510843, 16771758,
        8387925, 4194219, 2097141, 1048575, 524288, 262144, 131072, 65536,
        32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16,
        8, 4, 2, 1, 0, 0
    };

    typedef struct packed {
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] heading;
        logic              sat;
    } odo_pose_t;

    typedef struct {
        bit                is_cfg;
        cfg_reg_t          reg_sel;
        logic [WORD_W-1:0] cfg_value;
        logic [OP_W-1:0]   op;
        logic [WORD_W-1:0] cr, cl, px, py, ph;
        bit                typed;
        odo_pose_t         want;
    } stim_row_t;

    typedef enum {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_RARE} stall_mode_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [OP_W-1:0]       s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b1;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [WORD_W-1:0]     cfg_data = '0;

    // predictor state and register copies
    logic [WORD_W-1:0] dist_per_count = '0;
    logic [WORD_W-1:0] inv_track = INV_TRACK_RESET;
    logic [WORD_W-1:0] pos_x = '0;
    logic [WORD_W-1:0] pos_y = '0;
    logic [WORD_W-1:0] heading = '0;
    logic [WORD_W-1:0] ref_right = '0;
    logic [WORD_W-1:0] ref_left = '0;

    odo_pose_t   expected_poses[$];
    stim_row_t   directed_rows[$];
    logic [WORD_W-1:0] enc_right = '0;
    logic [WORD_W-1:0] enc_left = '0;
    int          fail_count = 0;
    int          idle_cycles = 0;
    int          ready_cycle = 0;
    stall_mode_t ready_mode = STALL_NONE;
    int          n_updates = 0;
    int          n_pose_loads = 0;
    int          n_unused = 0;
    int          n_cfg_writes = 0;
    int          n_clipped = 0;

    differential_drive_odometry #(.CORDIC_STEPS(CORDIC_STEPS)) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic logic [63:0] mag(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // cos and sin in Q2.30 of a Q3.29 angle in [0, 2pi]
    function automatic void cordic_rotate(input longint angle, output longint c,
                                          output longint s);
        longint z, x, y, nx;
        bit     flip;
        z = angle;
        x = longint'(CORDIC_GAIN_Q30);
        y = 0;
        flip = 1'b0;
        if (z > THREE_QUARTER) begin
            z -= TWO_PI;
        end else if (z > QUARTER_TURN) begin
            z -= HALF_TURN;
            flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z -= ATAN_STEP[i];
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z += ATAN_STEP[i];
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // mean travel times trig, Q24 x Q30 down to Q16, then saturating add
    function automatic logic [WORD_W-1:0] step_axis(input logic [WORD_W-1:0] p,
                                                    input longint sum, input longint trig,
                                                    inout bit sat);
        logic [63:0]  dist_mag;
        logic [127:0] prod;
        longint       d, r;
        dist_mag = mag(sum) * 64'(dist_per_count);
        prod = 128'(dist_mag) * 128'(mag(trig));
        d = longint'(64'(prod >> 39));
        if ((sum < 0) != (trig < 0)) d = -d;
        r = longint'($signed(p)) + d;
        if (r > POS_HI) begin
            sat = 1'b1;
            return POS_MAX;
        end
        if (r < POS_LO) begin
            sat = 1'b1;
            return POS_MIN;
        end
        return 32'(r);
    endfunction

    function automatic odo_pose_t advance_pose(input logic [OP_W-1:0] op,
                                               input logic [WORD_W-1:0] cr, cl,
                                               input logic [WORD_W-1:0] px, py, ph);
        longint       dr, dl, sum, diff, turn, h, co, si;
        logic [63:0]  diff_dist;
        logic [127:0] turn_full;
        bit           sat;
        odo_pose_t    res;
        sat = 1'b0;
        if (op == OP_UPDATE) begin
            dr = longint'($signed(cr - ref_right));
            dl = longint'($signed(cl - ref_left));
            sum = dr + dl;
            diff = dr - dl;
            diff_dist = mag(diff) * 64'(dist_per_count);
            turn_full = (128'(diff_dist) * 128'(inv_track)) >> 19;
            turn = (turn_full > 128'(TWO_PI)) ? TWO_PI : longint'(turn_full[63:0]);
            h = longint'(heading) + ((diff < 0) ? -turn : turn);
            if (h > TWO_PI) h -= TWO_PI;
            if (h < 0) h += TWO_PI;
            heading = 32'(h);
            cordic_rotate(longint'(heading), co, si);
            pos_x = step_axis(pos_x, sum, co, sat);
            pos_y = step_axis(pos_y, sum, si, sat);
            ref_right = cr;
            ref_left = cl;
        end else if (op == OP_SET_POSE || op == OP_SET_LATCH) begin
            pos_x = px;
            pos_y = py;
            heading = (ph > TWO_PI_Q29) ? TWO_PI_Q29 : ph;
            if (op == OP_SET_LATCH) begin
                ref_right = cr;
                ref_left = cl;
            end
        end
        res.x = pos_x;
        res.y = pos_y;
        res.heading = heading;
        res.sat = sat;
        return res;
    endfunction

    function automatic stim_row_t cfg_row(input cfg_reg_t sel, input logic [WORD_W-1:0] v);
        stim_row_t row;
        row = '{default: '0, reg_sel: sel, want: '0};
        row.is_cfg = 1'b1;
        row.cfg_value = v;
        return row;
    endfunction

    function automatic stim_row_t item_row(input logic [OP_W-1:0] op,
                                           input logic [WORD_W-1:0] cr, cl, px, py, ph);
        stim_row_t row;
        row = '{default: '0, reg_sel: REG_DIST_PER_COUNT, want: '0};
        row.op = op;
        row.cr = cr;
        row.cl = cl;
        row.px = px;
        row.py = py;
        row.ph = ph;
        return row;
    endfunction

    function automatic stim_row_t with_exp(input stim_row_t row,
                                           input logic [WORD_W-1:0] x, y, h, input logic sat);
        row.typed = 1'b1;
        row.want = '{x: x, y: y, heading: h, sat: sat};
        return row;
    endfunction

    // hold the item until taken, then record what it should produce
    task automatic drive_item(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] cr, cl,
                              input logic [WORD_W-1:0] px, py, ph,
                              input bit typed, input odo_pose_t want);
        odo_pose_t predicted;
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser = op;
        s_tdata = {ph, py, px, cl, cr};
        do @(posedge aclk); while (!s_tready);
        predicted = advance_pose(op, cr, cl, px, py, ph);
        expected_poses.push_back(typed ? want : predicted);
        case (op) inside
            OP_UPDATE:                 n_updates++;
            OP_SET_POSE, OP_SET_LATCH: n_pose_loads++;
            default:                   n_unused++;
        endcase
    endtask

    task automatic idle_gap(input int cycles);
        @(negedge aclk);
        s_tvalid = 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // stop sending and wait for every outstanding pose
    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (expected_poses.size() != 0) @(posedge aclk);
    endtask

    task automatic cfg_write(input cfg_reg_t sel, input logic [WORD_W-1:0] value);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = sel;
        cfg_data = value;
        do @(posedge aclk); while (!cfg_ready);
        if (sel == REG_DIST_PER_COUNT) dist_per_count = value;
        else inv_track = value;
        n_cfg_writes++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [WORD_W-1:0] rand_coord();
        if ($urandom_range(0, 4) == 0) return $urandom;
        return 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
    endfunction

    function automatic logic [WORD_W-1:0] rand_heading();
        if ($urandom_range(0, 6) == 0) return $urandom;
        return $urandom_range(0, TWO_PI_Q29);
    endfunction

    task automatic random_items(input int count);
        int              burst_left;
        int              pick;
        logic [OP_W-1:0] op;
        logic [WORD_W-1:0] cr, cl;
        burst_left = 0;
        for (int n = 0; n < count; n++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 12));
            end
            burst_left--;
            if ($urandom_range(0, 99) == 0) drain();
            pick = $urandom_range(0, 99);
            if (pick < 72) begin
                op = OP_UPDATE;
                if (pick < 7) begin
                    enc_right = $urandom;
                    enc_left = $urandom;
                end else begin
                    enc_right = enc_right + 32'($urandom_range(0, 4000)) - 32'd2000;
                    enc_left = enc_left + 32'($urandom_range(0, 4000)) - 32'd2000;
                end
                cr = enc_right;
                cl = enc_left;
            end else begin
                if (pick < 82) op = OP_SET_POSE;
                else if (pick < 95) op = OP_SET_LATCH;
                else op = OP_UNUSED;
                cr = $urandom;
                cl = $urandom;
                // a latch moves the reference, so track from the new counts
                if (op == OP_SET_LATCH) begin
                    if ($urandom_range(0, 1) == 0) begin
                        cr = enc_right;
                        cl = enc_left;
                    end
                    enc_right = cr;
                    enc_left = cl;
                end
            end
            drive_item(op, cr, cl, rand_coord(), rand_coord(), rand_heading(), 1'b0, '0);
        end
    endtask

    // result side: a randomly chosen stall pattern drives m_tready
    always @(negedge aclk) begin
        ready_cycle <= ready_cycle + 1;
        if (ready_cycle % 97 == 0) ready_mode <= stall_mode_t'($urandom_range(0, 3));
        case (ready_mode)
            STALL_NONE:     m_tready <= 1'b1;
            STALL_COIN:     m_tready <= 1'($urandom_range(0, 1));
            STALL_PERIODIC: m_tready <= (ready_cycle % 3 == 0);
            default:        m_tready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge aclk) begin : check_results
        odo_pose_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (m_tuser) n_clipped++;
            if (expected_poses.size() == 0) begin
                $error("result item with no pose expected: %h sat %b", m_tdata, m_tuser);
                fail_count++;
            end else begin
                want = expected_poses.pop_front();
                if (m_tdata[31:0] !== want.x) begin
                    $error("out_x: expected %h, got %h", want.x, m_tdata[31:0]);
                    fail_count++;
                end
                if (m_tdata[63:32] !== want.y) begin
                    $error("out_y: expected %h, got %h", want.y, m_tdata[63:32]);
                    fail_count++;
                end
                if (m_tdata[95:64] !== want.heading) begin
                    $error("out_heading: expected %h, got %h", want.heading, m_tdata[95:64]);
                    fail_count++;
                end
                if (m_tuser !== want.sat) begin
                    $error("saturated: expected %b, got %b", want.sat, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial begin
        stim_row_t row;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // pose right after reset, then a zero scale that moves nothing
        directed_rows.push_back(with_exp(item_row(OP_UNUSED, 0, 0, 0, 0, 0), 0, 0, 0, 0));
        directed_rows.push_back(with_exp(item_row(OP_UPDATE, 32'd1000, 32'hFFFF_FC18, 0, 0, 0),
                                         0, 0, 0, 0));
        directed_rows.push_back(with_exp(item_row(OP_SET_POSE, '1, 0, POS_MAX, POS_MIN,
                                                  TWO_PI_Q29),
                                         POS_MAX, POS_MIN, TWO_PI_Q29, 0));
        // heading above 2pi clips to 2pi
        directed_rows.push_back(with_exp(item_row(OP_SET_POSE, 0, '1, POS_MIN, POS_MAX, '1),
                                         POS_MIN, POS_MAX, TWO_PI_Q29, 0));
        directed_rows.push_back(with_exp(item_row(OP_SET_LATCH, POS_MIN, POS_MAX, 0, 0, 0),
                                         0, 0, 0, 0));
        // unused op ignores every field
        directed_rows.push_back(with_exp(item_row(OP_UNUSED, '1, '1, '1, '1, '1), 0, 0, 0, 0));
        directed_rows.push_back(cfg_row(REG_DIST_PER_COUNT, 32'h0100_0000));
        // counts wrap past the int32 limits, then a turn that clips at 2pi
        directed_rows.push_back(item_row(OP_UPDATE, 32'h8000_0064, 32'h8000_0063, 0, 0, 0));
        directed_rows.push_back(item_row(OP_UPDATE, 32'h8000_00C8, 32'h8000_0063, 0, 0, 0));
        directed_rows.push_back(item_row(OP_UNUSED, 0, 0, 0, 0, 0));
        // drive into each position limit, one quadrant at a time
        directed_rows.push_back(item_row(OP_SET_LATCH, 0, 0, 32'h7FFF_0000, 0, 0));
        directed_rows.push_back(item_row(OP_UPDATE, 32'd1000000, 32'd1000000, 0, 0, 0));
        directed_rows.push_back(item_row(OP_SET_LATCH, 0, 0, 32'h8001_0000, 0, PI_Q29));
        directed_rows.push_back(item_row(OP_UPDATE, 32'd1000000, 32'd1000000, 0, 0, 0));
        directed_rows.push_back(item_row(OP_SET_LATCH, 0, 0, 0, 32'h7FFF_0000, HALF_PI_Q29));
        directed_rows.push_back(item_row(OP_UPDATE, 32'd1000000, 32'd1000000, 0, 0, 0));
        directed_rows.push_back(item_row(OP_SET_LATCH, 0, 0, 0, 32'h8001_0000,
                                         THREE_HALF_PI_Q29));
        directed_rows.push_back(item_row(OP_UPDATE, 32'd1000000, 32'd1000000, 0, 0, 0));
        // full-scale factors: huge turns clip and wrap both ways
        directed_rows.push_back(cfg_row(REG_INV_TRACK, '1));
        directed_rows.push_back(cfg_row(REG_DIST_PER_COUNT, '1));
        directed_rows.push_back(item_row(OP_SET_LATCH, 0, 0, 0, 0, 32'd100));
        directed_rows.push_back(item_row(OP_UPDATE, 32'h7FFF_FFFF, 32'h8000_0001, 0, 0, 0));
        directed_rows.push_back(item_row(OP_UPDATE, 0, 32'h7FFF_FFFF, 0, 0, 0));
        directed_rows.push_back(cfg_row(REG_INV_TRACK, 0));
        directed_rows.push_back(item_row(OP_UPDATE, 32'd12345, 32'hFFFF_FC19, 0, 0, 0));

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.is_cfg) begin
                drain();
                cfg_write(row.reg_sel, row.cfg_value);
            end else begin
                drive_item(row.op, row.cr, row.cl, row.px, row.py, row.ph, row.typed, row.want);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            case (phase)
                0: begin
                    cfg_write(REG_DIST_PER_COUNT, $urandom_range(32'h1_0000, 32'h40_0000));
                    cfg_write(REG_INV_TRACK, INV_TRACK_RESET);
                end
                1: begin
                    cfg_write(REG_DIST_PER_COUNT, '1);
                    cfg_write(REG_INV_TRACK, '1);
                end
                2: begin
                    cfg_write(REG_DIST_PER_COUNT, 0);
                    cfg_write(REG_INV_TRACK, $urandom);
                end
                3: begin
                    cfg_write(REG_DIST_PER_COUNT, $urandom);
                    cfg_write(REG_INV_TRACK, 0);
                end
                4: begin
                    cfg_write(REG_DIST_PER_COUNT, $urandom_range(1, 32'h1000));
                    cfg_write(REG_INV_TRACK, $urandom_range(32'h10_0000, 32'h400_0000));
                end
                default: begin
                    cfg_write(REG_DIST_PER_COUNT, $urandom_range(32'h1_0000, 32'h40_0000));
                    cfg_write(REG_INV_TRACK, $urandom_range(32'h1_0000, 32'h100_0000));
                end
            endcase
            random_items(ITEMS_PER_PHASE);
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Covered %0d count updates, %0d pose loads and %0d unused ops over %0d writes",
                 n_updates, n_pose_loads, n_unused, n_cfg_writes);
        $display("of the scale registers; %0d results came back clipped at a limit.", n_clipped);
        if (fail_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/ddo_pkg.sv
src/ddo_mul.sv
src/ddo_cordic.sv
src/differential_drive_odometry.sv
dv/tb.sv
